// ===== rtl/ssf_pkg.sv =====
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared codes and widths for the subarray sum target finder.
// ----------------------------------------------------------------------------
`default_nettype none

package ssf_pkg;

  // Width of prefix sums and of the target register.
  localparam int unsigned SUM_W = 40;

  // Operation codes carried on the slave tuser.
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_FETCH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Status codes carried on the master tuser.
  localparam logic [2:0] ST_PUSHED  = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_FOUND   = 3'd2;
  localparam logic [2:0] ST_NONE    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

endpackage : ssf_pkg

`default_nettype wire

// ===== rtl/subarray_sum_target_finder.sv =====
// ----------------------------------------------------------------------------
// subarray_sum_target_finder
// Stores prefix sums of pushed elements and reports, one per fetch, the
// contiguous ranges whose sum equals the target register.
// ----------------------------------------------------------------------------
//
//  channel   | dir | payload                              | transfer when
//  ----------+-----+--------------------------------------+----------------------
//  s_axis    | in  | tuser: operation, tdata: element     | tvalid & tready
//  m_axis    | out | tuser: status, tdata: left, right    | tvalid & tready
//  cfg       | in  | cfg_wdata_i: target_sum              | cfg_we_i
//
//  Push and clear are taken in S_IDLE, then pass through S_RESP. A fetch
//  that finds the store sorted walks candidate entries (a read state, then
//  a compare state) through read port a and the shared subtractor. The
//  first fetch after a push, clear or target write runs an insertion sort
//  first: each element is read, then S_SORT_C shifts larger entries up one
//  slot until the key lands. After reset S_INIT writes the empty prefix into
//  entry 0; no transfer is taken meanwhile. Reset is asynchronous, active low.
//  s_axis is taken whenever the sequencer is idle, even while a result still
//  waits on m_axis; a stalled result holds the sequencer in its result state.
//
`default_nettype none

module subarray_sum_target_finder
  import ssf_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 256,
  parameter int unsigned ELEMENT_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config
  input  wire logic                          cfg_we_i,
  input  wire logic [SUM_W-1:0]              cfg_wdata_i,   // target_sum
  // slave stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [((ELEMENT_BITS+7)/8)*8-1:0] s_axis_tdata, // element
  input  wire logic [1:0]                    s_axis_tuser,  // operation
  // master stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [((2*$clog2(MAX_ELEMENTS+1)+7)/8)*8-1:0] m_axis_tdata, // left, right
  output logic [2:0]                         m_axis_tuser   // status
);

  localparam int unsigned AW       = $clog2(MAX_ELEMENTS + 1);  // index / position
  localparam int unsigned CW       = $clog2(MAX_ELEMENTS + 2);  // cursors
  localparam int unsigned WW       = AW + SUM_W;                // memory word
  localparam int unsigned OUT_TDW  = ((2*AW+7)/8)*8;
  localparam int unsigned DW       = SUM_W + 2;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_SORT_I  = 4'd2;
  localparam logic [3:0] S_SORT_V  = 4'd3;
  localparam logic [3:0] S_SORT_C  = 4'd4;
  localparam logic [3:0] S_SORT_W  = 4'd5;
  localparam logic [3:0] S_ENTER   = 4'd6;
  localparam logic [3:0] S_ENTER2  = 4'd7;
  localparam logic [3:0] S_HS_RD   = 4'd8;
  localparam logic [3:0] S_HS_CMP  = 4'd9;
  localparam logic [3:0] S_SC_RD   = 4'd10;
  localparam logic [3:0] S_SC_CMP  = 4'd11;
  localparam logic [3:0] S_RESP    = 4'd12;

  // prefix store: word = {position, value}
  logic [WW-1:0] mem_q [0:MAX_ELEMENTS];
  logic [WW-1:0] rd_a_q, rd_b_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, ra, rb;
  logic [WW-1:0] mem_wd;

  logic [3:0]       state_q, state_d;
  logic [AW-1:0]    count_q, count_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             sorted_q, sorted_d;
  logic [CW-1:0]    hgs_q, hgs_d;     // first entry of the high group
  logic [CW-1:0]    a_q, a_d;         // low cursor
  logic [CW-1:0]    b_q, b_d;         // high cursor, also the group search pointer
  logic [CW-1:0]    i_q, i_d;         // sort outer index
  logic [AW-1:0]    j_q, j_d;         // sort insertion slot
  logic [WW-1:0]    key_q, key_d;     // sort key, or the entry under the low cursor
  logic [SUM_W-1:0] target_q;
  logic [DW-1:0]    dist_q;           // |target|

  logic [2:0]       res_st_q, res_st_d;
  logic [AW-1:0]    res_l_q, res_l_d, res_r_q, res_r_d;
  logic             out_load;
  logic             m_valid_q;
  logic [2:0]       m_st_q;
  logic [AW-1:0]    m_l_q, m_r_q;

  // element sign extended (or cut) to the sum width
  logic signed [ELEMENT_BITS-1:0] elem_s;
  logic [SUM_W-1:0]               sum_new;
  logic [CW-1:0]                  cnt_c;

  assign elem_s  = $signed(s_axis_tdata[ELEMENT_BITS-1:0]);
  assign sum_new = sum_q + SUM_W'(elem_s);
  assign cnt_c   = CW'(count_q);

  // shared subtractor: entry under the read port minus the key
  logic signed [DW-1:0] diff;
  logic                 cmp_gt;
  logic [AW-1:0]        pa, pb;
  logic                 dir_ok;

  assign diff = $signed({{2{rd_a_q[SUM_W-1]}}, rd_a_q[SUM_W-1:0]})
              - $signed({{2{key_q[SUM_W-1]}}, key_q[SUM_W-1:0]});
  assign pa   = key_q[WW-1:SUM_W];
  assign pb   = rd_a_q[WW-1:SUM_W];
  // sort order: value, then position
  assign cmp_gt = ($signed(rd_a_q[SUM_W-1:0]) > $signed(key_q[SUM_W-1:0])) ||
                  ((rd_a_q[SUM_W-1:0] == key_q[SUM_W-1:0]) && (pb > pa));
  // pair orientation decides the sign of the range sum
  assign dir_ok = (dist_q == '0) || (target_q[SUM_W-1] ? (pb < pa) : (pb > pa));

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    sum_d    = sum_q;
    sorted_d = sorted_q;
    hgs_d    = hgs_q;
    a_d      = a_q;
    b_d      = b_q;
    i_d      = i_q;
    j_d      = j_q;
    key_d    = key_q;
    res_st_d = res_st_q;
    res_l_d  = res_l_q;
    res_r_d  = res_r_q;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = '0;
    ra       = '0;
    rb       = '0;
    out_load = 1'b0;

    case (state_q)
      S_INIT: begin
        mem_we  = 1'b1;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          res_l_d = '0;
          res_r_d = '0;
          case (s_axis_tuser)
            OP_PUSH: begin
              state_d = S_RESP;
              if (cnt_c >= CW'(MAX_ELEMENTS)) begin
                res_st_d = ST_FULL;
              end else begin
                res_st_d = ST_PUSHED;
                sum_d    = sum_new;
                count_d  = count_q + 1'b1;
                sorted_d = 1'b0;
                mem_we   = 1'b1;
                mem_wa   = count_q + 1'b1;
                mem_wd   = {count_q + 1'b1, sum_new};
              end
            end
            OP_FETCH: begin
              if (!sorted_q) begin
                i_d     = CW'(1);
                state_d = S_SORT_I;
              end else if (a_q > cnt_c) begin
                res_st_d = ST_NONE;
                state_d  = S_RESP;
              end else begin
                state_d = S_SC_RD;
              end
            end
            OP_CLEAR: begin
              count_d  = '0;
              sum_d    = '0;
              sorted_d = 1'b0;
              hgs_d    = '0;
              a_d      = '0;
              b_d      = '0;
              mem_we   = 1'b1;
              res_st_d = ST_CLEARED;
              state_d  = S_RESP;
            end
            default: ;  // unused code: taken, no result
          endcase
        end
      end
      S_SORT_I: begin
        if (i_q > cnt_c) begin
          sorted_d = 1'b1;
          hgs_d    = '0;
          a_d      = '0;
          state_d  = S_ENTER;
        end else begin
          ra      = i_q[AW-1:0];
          state_d = S_SORT_V;
        end
      end
      S_SORT_V: begin
        key_d   = rd_a_q;
        j_d     = i_q[AW-1:0];
        ra      = i_q[AW-1:0] - 1'b1;
        state_d = S_SORT_C;
      end
      S_SORT_C: begin
        mem_we = 1'b1;
        mem_wa = j_q;
        if (cmp_gt) begin
          mem_wd = rd_a_q;
          j_d    = j_q - 1'b1;
          ra     = j_q - AW'(2);
          if (j_q == AW'(1)) begin
            state_d = S_SORT_W;
          end
        end else begin
          mem_wd  = key_q;
          i_d     = i_q + 1'b1;
          state_d = S_SORT_I;
        end
      end
      S_SORT_W: begin
        mem_we  = 1'b1;
        mem_wd  = key_q;
        i_d     = i_q + 1'b1;
        state_d = S_SORT_I;
      end
      S_ENTER: begin
        if (a_q > cnt_c) begin
          res_st_d = ST_NONE;
          state_d  = S_RESP;
        end else begin
          ra      = a_q[AW-1:0];
          rb      = a_q[AW-1:0] - 1'b1;
          state_d = S_ENTER2;
        end
      end
      S_ENTER2: begin
        key_d = rd_a_q;
        if (dist_q == '0) begin
          b_d     = a_q + 1'b1;
          state_d = S_SC_RD;
        end else if ((a_q == '0) || (rd_a_q[SUM_W-1:0] != rd_b_q[SUM_W-1:0])) begin
          // new low group: move the high group start forward
          b_d     = (hgs_q > a_q + 1'b1) ? hgs_q : a_q + 1'b1;
          state_d = S_HS_RD;
        end else begin
          b_d     = hgs_q;
          state_d = S_SC_RD;
        end
      end
      S_HS_RD: begin
        if (b_q > cnt_c) begin
          hgs_d   = b_q;
          state_d = S_SC_RD;
        end else begin
          ra      = b_q[AW-1:0];
          state_d = S_HS_CMP;
        end
      end
      S_HS_CMP: begin
        if (diff < $signed(dist_q)) begin
          b_d     = b_q + 1'b1;
          state_d = S_HS_RD;
        end else begin
          hgs_d   = b_q;
          state_d = S_SC_RD;
        end
      end
      S_SC_RD: begin
        if (b_q > cnt_c) begin
          a_d     = a_q + 1'b1;
          state_d = S_ENTER;
        end else begin
          ra      = b_q[AW-1:0];
          state_d = S_SC_CMP;
        end
      end
      S_SC_CMP: begin
        if (diff > $signed(dist_q)) begin
          a_d     = a_q + 1'b1;
          state_d = S_ENTER;
        end else begin
          b_d = b_q + 1'b1;
          if ((diff == $signed(dist_q)) && dir_ok) begin
            res_st_d = ST_FOUND;
            res_l_d  = ((pa < pb) ? pa : pb) + 1'b1;
            res_r_d  = (pa < pb) ? pb : pa;
            state_d  = S_RESP;
          end else begin
            state_d = S_SC_RD;
          end
        end
      end
      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a new target restarts the enumeration
    if (cfg_we_i) begin
      sorted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      count_q   <= '0;
      sum_q     <= '0;
      sorted_q  <= 1'b0;
      hgs_q     <= '0;
      a_q       <= '0;
      b_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      target_q  <= '0;
      dist_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      sorted_q <= sorted_d;
      hgs_q    <= hgs_d;
      a_q      <= a_d;
      b_q      <= b_d;
      i_q      <= i_d;
      j_q      <= j_d;
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
        dist_q   <= cfg_wdata_i[SUM_W-1] ? DW'(-$signed({1'b1, cfg_wdata_i}))
                                         : DW'(cfg_wdata_i);
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    res_st_q <= res_st_d;
    res_l_q  <= res_l_d;
    res_r_q  <= res_r_d;
    if (out_load) begin
      m_st_q <= res_st_q;
      m_l_q  <= res_l_q;
      m_r_q  <= res_r_q;
    end
  end

  // prefix store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_a_q <= mem_q[ra];
    rd_b_q <= mem_q[rb];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_st_q;
  assign m_axis_tdata  = OUT_TDW'({m_r_q, m_l_q});

endmodule : subarray_sum_target_finder

`default_nettype wire

// ===== rtl/ssf_checker.sv =====
// ----------------------------------------------------------------------------
// ssf_checker
// Port-level checks for the subarray sum target finder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ssf_checker
  import ssf_pkg::*;
#(
  parameter int unsigned PW      = 9,
  parameter int unsigned OUT_TDW = 24
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [OUT_TDW-1:0] m_axis_tdata,
  input wire logic [2:0]         m_axis_tuser
);

  logic [PW-1:0] left, right;
  assign left  = m_axis_tdata[PW-1:0];
  assign right = m_axis_tdata[2*PW-1:PW];

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a found range is nonempty and 1-based
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FOUND) |-> (left != '0) && (left <= right))
    else $error("bad range bounds");

  // other statuses carry no range
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_FOUND) |-> (left == '0) && (right == '0))
    else $error("range on non-found status");

  // status is a defined code
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_PUSHED) || (m_axis_tuser == ST_FULL) ||
      (m_axis_tuser == ST_FOUND) || (m_axis_tuser == ST_NONE) ||
      (m_axis_tuser == ST_CLEARED))
    else $error("undefined status");

endmodule : ssf_checker

bind subarray_sum_target_finder ssf_checker #(
  .PW      (AW),
  .OUT_TDW (OUT_TDW)
) u_ssf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
